FILE: rtl/gtdm_pkg.sv
// ----------------------------------------------------------------------------
// gtdm_pkg
// shared types and constants of the gamepad tank drive mixer
// ----------------------------------------------------------------------------
package gtdm_pkg;

    localparam int STICK_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int SPEED_W   = 8;
    localparam int WEAPON_W  = 16;
    // arithmetic width for the signed track commands
    localparam int MIX_W     = 11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEAPON_FULL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEAPON_HALF = 2'd2;

    localparam logic [7:0] DEADZONE_RESET = 8'd20;

    // map scaling constants
    localparam logic [8:0]       SPEED_MUL  = 9'd510;
    localparam logic [8:0]       TURN_MUL   = 9'd446;
    localparam logic [10:0]      AXIS_MID   = 11'd512;
    localparam logic [MIX_W-1:0] SPEED_OFS  = 11'd255;
    localparam logic [MIX_W-1:0] TURN_OFS   = 11'd223;
    localparam logic [8:0]       SPEED_MAX  = 9'd255;

    // weapon flag codes
    localparam logic [1:0] WFLAG_OFF  = 2'b00;
    localparam logic [1:0] WFLAG_FULL = 2'b01;
    localparam logic [1:0] WFLAG_HALF = 2'b10;

    typedef struct packed {
        logic load;
        logic square;
        logic cube;
        logic scale;
        logic mix;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_sts;

endpackage

FILE: rtl/gtdm_ctrl.sv
// ----------------------------------------------------------------------------
// gtdm_ctrl
// sequencer that steps one item through square, cube, scale and mix
// ----------------------------------------------------------------------------
module gtdm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gtdm_pkg::t_dp_sts i_sts,
    output gtdm_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SQUARE = 5'b00010,
        S_CUBE   = 5'b00100,
        S_SCALE  = 5'b01000,
        S_MIX    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_SQUARE;
            S_SQUARE: n_state = S_CUBE;
            S_CUBE:   n_state = S_SCALE;
            S_SCALE:  n_state = S_MIX;
            S_MIX:    if (!i_sts.out_full) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_valid;
    assign o_cmd.square = (r_state == S_SQUARE);
    assign o_cmd.cube   = (r_state == S_CUBE);
    assign o_cmd.scale  = (r_state == S_SCALE);
    // result register must be free before the item is written into it
    assign o_cmd.mix    = (r_state == S_MIX) && !i_sts.out_full;

endmodule

FILE: rtl/gtdm_datapath.sv
// ----------------------------------------------------------------------------
// gtdm_datapath
// mode state, configuration registers, stick mixing and result register
// ----------------------------------------------------------------------------
module gtdm_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  gtdm_pkg::t_dp_cmd                     i_cmd,
    output gtdm_pkg::t_dp_sts                     o_sts,
    input  logic                                  i_cfg_we,
    input  logic [gtdm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gtdm_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                  i_button_a,
    input  logic                                  i_button_b,
    input  logic                                  i_button_x,
    input  logic                                  i_button_y,
    input  logic signed [gtdm_pkg::STICK_W-1:0]   i_stick_x,
    input  logic signed [gtdm_pkg::STICK_W-1:0]   i_stick_y,
    input  logic                                  i_ready,
    output logic                                  o_valid,
    output logic                                  o_drive_enable,
    output logic                                  o_left_forward,
    output logic [gtdm_pkg::SPEED_W-1:0]          o_left_speed,
    output logic                                  o_right_forward,
    output logic [gtdm_pkg::SPEED_W-1:0]          o_right_speed,
    output logic [gtdm_pkg::WEAPON_W-1:0]         o_weapon_speed,
    output logic                                  o_weapon_full,
    output logic                                  o_weapon_half
);

    // configuration
    logic [7:0]                        r_deadzone;
    logic [gtdm_pkg::WEAPON_W-1:0]     r_wfull_cfg;
    logic [gtdm_pkg::WEAPON_W-1:0]     r_whalf_cfg;

    // mode state
    logic [3:0]                        r_prev_btn;
    logic                              r_manual;
    logic [gtdm_pkg::WEAPON_W-1:0]     r_wspeed;
    logic [1:0]                        r_wflags;

    logic [3:0]                        n_now;
    logic [3:0]                        n_rise;
    logic                              n_manual;
    logic [gtdm_pkg::WEAPON_W-1:0]     n_wspeed;
    logic [1:0]                        n_wflags;

    // arithmetic pipeline registers
    logic [9:0]                        r_abs_x;
    logic                              r_neg_x;
    logic [10:0]                       r_fwd_ofs;
    logic [18:0]                       r_sq;
    logic [27:0]                       r_cube;
    logic signed [gtdm_pkg::MIX_W-1:0] r_speed;
    logic signed [gtdm_pkg::MIX_W-1:0] r_eff;

    logic [9:0]                        n_abs_x;
    logic [19:0]                       w_sq_prod;
    logic [28:0]                       w_cube_prod;
    logic [9:0]                        w_turn_mag;
    logic [10:0]                       w_turn_ofs;
    logic [19:0]                       w_speed_prod;
    logic [19:0]                       w_eff_prod;
    logic signed [gtdm_pkg::MIX_W-1:0] w_left;
    logic signed [gtdm_pkg::MIX_W-1:0] w_right;
    logic                              w_left_fwd;
    logic                              w_right_fwd;
    logic [7:0]                        w_left_mag;
    logic [7:0]                        w_right_mag;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone  <= gtdm_pkg::DEADZONE_RESET;
            r_wfull_cfg <= '0;
            r_whalf_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gtdm_pkg::CFG_DEADZONE:    r_deadzone  <= i_cfg_data[7:0];
                gtdm_pkg::CFG_WEAPON_FULL: r_wfull_cfg <= i_cfg_data;
                gtdm_pkg::CFG_WEAPON_HALF: r_whalf_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ----------------------------------------------------- button edge logic
    // rising edges applied in order a, b, x, y
    always_comb begin
        n_now    = {i_button_y, i_button_x, i_button_b, i_button_a};
        n_rise   = n_now & ~r_prev_btn;
        n_manual = r_manual;
        n_wspeed = r_wspeed;
        n_wflags = r_wflags;
        if (n_rise[0]) begin
            n_manual = 1'b0;
            n_wflags = gtdm_pkg::WFLAG_OFF;
            n_wspeed = '0;
        end
        if (n_rise[1]) begin
            if (!n_manual) begin
                n_manual = 1'b1;
                n_wflags = gtdm_pkg::WFLAG_OFF;
            end else begin
                n_manual = 1'b0;
                n_wflags = gtdm_pkg::WFLAG_OFF;
                n_wspeed = '0;
            end
        end
        if (n_rise[2]) begin
            if (n_wspeed == r_wfull_cfg) begin
                n_wspeed = '0;
                n_wflags = gtdm_pkg::WFLAG_OFF;
            end else begin
                n_wspeed = r_wfull_cfg;
                n_wflags = gtdm_pkg::WFLAG_FULL;
            end
        end
        if (n_rise[3]) begin
            if (n_wspeed == r_whalf_cfg) begin
                n_wspeed = '0;
                n_wflags = gtdm_pkg::WFLAG_OFF;
            end else begin
                n_wspeed = r_whalf_cfg;
                n_wflags = gtdm_pkg::WFLAG_HALF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_btn <= '0;
            r_manual   <= 1'b0;
            r_wspeed   <= '0;
            r_wflags   <= gtdm_pkg::WFLAG_OFF;
        end else if (i_cmd.load) begin
            r_prev_btn <= n_now;
            r_manual   <= n_manual;
            r_wspeed   <= n_wspeed;
            r_wflags   <= n_wflags;
        end
    end

    // ------------------------------------------------------------ arithmetic
    // magnitude of -512 still fits 10 unsigned bits
    assign n_abs_x      = i_stick_x[9] ? 10'(-i_stick_x) : i_stick_x;
    assign w_sq_prod    = r_abs_x * r_abs_x;
    assign w_cube_prod  = r_sq * {9'd0, r_abs_x};
    // cube truncates toward zero, so shift the magnitude and restore sign
    assign w_turn_mag   = r_cube[27:18];
    assign w_turn_ofs   = r_neg_x ? (gtdm_pkg::AXIS_MID - {1'b0, w_turn_mag})
                                  : (gtdm_pkg::AXIS_MID + {1'b0, w_turn_mag});
    assign w_speed_prod = r_fwd_ofs * gtdm_pkg::SPEED_MUL;
    assign w_eff_prod   = w_turn_ofs * gtdm_pkg::TURN_MUL;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_abs_x   <= n_abs_x;
            r_neg_x   <= i_stick_x[9];
            // 512 - stick_y, always 1..1024
            r_fwd_ofs <= gtdm_pkg::AXIS_MID - {i_stick_y[9], i_stick_y};
        end
        if (i_cmd.square) begin
            r_sq <= w_sq_prod[18:0];
        end
        if (i_cmd.cube) begin
            r_cube <= w_cube_prod[27:0];
        end
        if (i_cmd.scale) begin
            r_speed <= $signed({1'b0, w_speed_prod[19:10]}) - $signed(gtdm_pkg::SPEED_OFS);
            r_eff   <= $signed({2'b00, w_eff_prod[18:10]}) - $signed(gtdm_pkg::TURN_OFS);
        end
    end

    assign w_left  = r_speed + r_eff;
    assign w_right = r_speed - r_eff;

    // deadzone and clamp for one track
    function automatic logic [8:0] shape_track(
        input logic signed [gtdm_pkg::MIX_W-1:0] v,
        input logic [7:0]                        dz
    );
        logic [gtdm_pkg::MIX_W-1:0] mag;
        logic                       fwd;
        logic [7:0]                 spd;
        begin
            mag = v[gtdm_pkg::MIX_W-1] ? gtdm_pkg::MIX_W'(-v) : v;
            fwd = !v[gtdm_pkg::MIX_W-1];
            if (mag < {3'd0, dz}) begin
                fwd = 1'b1;
                spd = '0;
            end else if (mag > {2'd0, gtdm_pkg::SPEED_MAX}) begin
                spd = gtdm_pkg::SPEED_MAX[7:0];
            end else begin
                spd = mag[7:0];
            end
            shape_track = {fwd, spd};
        end
    endfunction

    assign {w_left_fwd, w_left_mag}   = shape_track(w_left, r_deadzone);
    assign {w_right_fwd, w_right_mag} = shape_track(w_right, r_deadzone);

    // ------------------------------------------------------- result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.mix) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix) begin
            o_drive_enable  <= r_manual;
            o_left_forward  <= r_manual ? w_left_fwd : 1'b1;
            o_left_speed    <= r_manual ? w_left_mag : '0;
            o_right_forward <= r_manual ? w_right_fwd : 1'b1;
            o_right_speed   <= r_manual ? w_right_mag : '0;
            o_weapon_speed  <= r_wspeed;
            o_weapon_full   <= r_wflags[0];
            o_weapon_half   <= r_wflags[1];
        end
    end

    assign o_sts.out_full = o_valid && !i_ready;

endmodule

FILE: rtl/gamepad_tank_drive_mixer.sv
// ----------------------------------------------------------------------------
// gamepad_tank_drive_mixer
// button mode logic and tank drive mixing for one gamepad report per item
// ----------------------------------------------------------------------------
// the result register is written in the mix step, after square, cube and scale
// a new item is taken only once the sequencer is back in idle, since it steps
//   each item through the square, cube, scale and mix steps on one set of registers
// a stalled result holds the sequencer in its mix step until taken
// reset: synchronous active low; modes off, weapon off, deadzone 20
module gamepad_tank_drive_mixer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gtdm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gtdm_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_button_a,
    input  logic                                i_button_b,
    input  logic                                i_button_x,
    input  logic                                i_button_y,
    input  logic signed [gtdm_pkg::STICK_W-1:0] i_stick_x,
    input  logic signed [gtdm_pkg::STICK_W-1:0] i_stick_y,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_drive_enable,
    output logic                                o_left_forward,
    output logic [gtdm_pkg::SPEED_W-1:0]        o_left_speed,
    output logic                                o_right_forward,
    output logic [gtdm_pkg::SPEED_W-1:0]        o_right_speed,
    output logic [gtdm_pkg::WEAPON_W-1:0]       o_weapon_speed,
    output logic                                o_weapon_full,
    output logic                                o_weapon_half
);

    gtdm_pkg::t_dp_cmd w_cmd;
    gtdm_pkg::t_dp_sts w_sts;

    gtdm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    gtdm_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_button_a      (i_button_a),
        .i_button_b      (i_button_b),
        .i_button_x      (i_button_x),
        .i_button_y      (i_button_y),
        .i_stick_x       (i_stick_x),
        .i_stick_y       (i_stick_y),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_drive_enable  (o_drive_enable),
        .o_left_forward  (o_left_forward),
        .o_left_speed    (o_left_speed),
        .o_right_forward (o_right_forward),
        .o_right_speed   (o_right_speed),
        .o_weapon_speed  (o_weapon_speed),
        .o_weapon_full   (o_weapon_full),
        .o_weapon_half   (o_weapon_half)
    );

endmodule
